// ===== hw/rtl/ate_pkg.sv =====
`default_nettype none

package ate_pkg;

  // Calibration and CORDIC sizing
  localparam int unsigned CAL_SAMPLES  = 200;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned STEP_W       = 5;
  localparam int unsigned SUM_W        = 24;
  localparam int unsigned CW           = 34;
  localparam int unsigned ZW           = 25;

  // Reciprocal of CAL_SAMPLES, rounded up, exact for any sum magnitude up to 2^(SUM_W-1)
  localparam int unsigned     DIV_SHIFT = 31;
  localparam longint unsigned DIV_MULT  =
      ((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);

  // Angle limits: +-180 degrees in 1/32768 degree, output limit in 1/128 degree
  localparam int signed ANG_LIMIT = 5898240;
  localparam int signed QUARTER   = 2949120;
  localparam int signed OUT_LIMIT = 23040;

  // Configuration register indexes
  localparam logic [1:0] CFG_ALPHA    = 2'd0;
  localparam logic [1:0] CFG_YAW_GAIN = 2'd1;
  localparam logic [1:0] CFG_GRAVITY  = 2'd2;

  // Arctangent of 2^-i in 1/32768 degree, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic signed [ZW-1:0] val;
    case (idx)
      5'd0:  val = 25'sd1474560;
      5'd1:  val = 25'sd870484;
      5'd2:  val = 25'sd459940;
      5'd3:  val = 25'sd233473;
      5'd4:  val = 25'sd117189;
      5'd5:  val = 25'sd58652;
      5'd6:  val = 25'sd29333;
      5'd7:  val = 25'sd14667;
      5'd8:  val = 25'sd7334;
      5'd9:  val = 25'sd3667;
      5'd10: val = 25'sd1833;
      5'd11: val = 25'sd917;
      5'd12: val = 25'sd458;
      5'd13: val = 25'sd229;
      5'd14: val = 25'sd115;
      5'd15: val = 25'sd57;
      5'd16: val = 25'sd29;
      5'd17: val = 25'sd14;
      5'd18: val = 25'sd7;
      5'd19: val = 25'sd4;
      5'd20: val = 25'sd2;
      5'd21: val = 25'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/accel_tilt_yaw_estimator.sv =====
// Measurement transaction: runs from acceptance to result through two passes
// through the one CORDIC unit.
// Throughput: one transaction at a time; the input stalls until the result is queued.
// Calibration transaction: accumulates the sample; the last one also runs four divisions, one per sum.
// Reset (asynchronous, active low) clears sums, offsets, filters and yaw and
// restores the register defaults.
`default_nettype none

module accel_tilt_yaw_estimator import ate_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               action_i,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  input  wire logic signed [15:0] rate_z_i,
  // Output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      roll_o,
  output logic signed [15:0]      pitch_o,
  output logic signed [31:0]      yaw_o,
  output logic                    calibrated_o,
  // Configuration write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [16:0]        cfg_data_i
);

  // Sequencer states, one-hot
  typedef enum logic [13:0] {
    ST_IDLE     = 14'h0001,
    ST_DIV      = 14'h0002,
    ST_DIV_WAIT = 14'h0004,
    ST_SQ_A     = 14'h0008,
    ST_SQ_B     = 14'h0010,
    ST_SQ_C     = 14'h0020,
    ST_PITCH    = 14'h0040,
    ST_ROOT     = 14'h0080,
    ST_ROLL     = 14'h0100,
    ST_EMA_MUL  = 14'h0200,
    ST_EMA_ACC  = 14'h0400,
    ST_YAW_MUL  = 14'h0800,
    ST_YAW_ACC  = 14'h1000,
    ST_OUT      = 14'h2000
  } state_e;

  localparam logic [16:0] ALPHA_ONE = 17'h10000;
  localparam logic signed [16:0] RND_MAX = 17'(OUT_LIMIT);
  localparam logic signed [16:0] RND_MIN = 17'(-OUT_LIMIT);

  state_e state_q, state_d;

  // Configuration
  logic [16:0] alpha_q;
  logic [15:0] yaw_gain_q;
  logic [14:0] gravity_q;

  // Calibration state: index 0..2 accelerometer X/Y/Z, index 3 gyro Z
  logic [7:0]              count_q;
  logic signed [SUM_W-1:0] sum_q [4];
  logic [15:0]             off_q [4];
  logic                    cal_done_q;
  logic [1:0]              div_idx_q;

  // Measurement datapath
  logic signed [15:0]   ax_q, ay_q, az_q, dr_q;
  logic [31:0]          ysq_q;
  logic signed [ZW-1:0] pitch_ang_q, roll_ang_q;
  logic signed [31:0]   filt_q [2];
  logic                 ema_k_q;
  logic signed [47:0]   yaw_q;

  // Shared multiplier
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [51:0] prod_q;

  // Output register
  logic               out_valid_q;
  logic signed [15:0] roll_out_q, pitch_out_q;
  logic signed [31:0] yaw_out_q;
  logic               cal_out_q;

  // Unit handshakes
  logic                 div_start, div_busy;
  logic [15:0]          div_quot;
  logic                 sqrt_start, sqrt_busy;
  logic [15:0]          sqrt_root;
  logic                 cor_start, cor_busy;
  logic signed [17:0]   cor_y, cor_x;
  logic signed [ZW-1:0] cor_angle;

  logic               accept;
  logic               last_cal;
  logic [31:0]        sq_sum;
  logic [16:0]        alpha_sat;
  logic signed [ZW-1:0] ema_ang;
  logic signed [31:0] ema_f;
  logic signed [33:0] ema_diff;
  logic signed [48:0] yaw_sum;
  logic               out_load;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign last_cal    = ({1'b0, count_q} + 9'd1) >= 9'(CAL_SAMPLES);
  assign sq_sum      = prod_q[31:0] + ysq_q;
  assign alpha_sat   = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign ema_ang     = ema_k_q ? pitch_ang_q : roll_ang_q;
  assign ema_f       = filt_q[ema_k_q];
  assign ema_diff    = {ema_ang[ZW-1], ema_ang, 8'b0} - {{2{ema_f[31]}}, ema_f};
  assign yaw_sum     = {yaw_q[47], yaw_q} + {{16{prod_q[32]}}, prod_q[32:0]};
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // Round half up from 16 fraction bits and clamp to +-180 degrees
  function automatic logic signed [15:0] round_angle(input logic signed [31:0] f);
    logic signed [32:0] t;
    logic signed [16:0] r;
    t = {f[31], f} + 33'sd32768;
    r = t[32:16];
    if (r > RND_MAX) begin
      r = RND_MAX;
    end else if (r < RND_MIN) begin
      r = RND_MIN;
    end
    return r[15:0];
  endfunction

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= 17'd19661;
      yaw_gain_q <= 16'd6404;
      gravity_q  <= 15'd16384;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ALPHA:    alpha_q    <= cfg_data_i;
        CFG_YAW_GAIN: yaw_gain_q <= cfg_data_i[15:0];
        CFG_GRAVITY:  gravity_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state and unit starts
  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    cor_start  = 1'b0;
    cor_y      = {{2{ay_q[15]}}, ay_q};
    cor_x      = {{2{az_q[15]}}, az_q};
    unique case (state_q)
      ST_IDLE: begin
        if (accept && action_i) begin
          state_d = ST_SQ_A;
        end else if (accept && !cal_done_q && last_cal) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          state_d = (div_idx_q == 2'd3) ? ST_IDLE : ST_DIV;
        end
      end
      ST_SQ_A: state_d = ST_SQ_B;
      ST_SQ_B: state_d = ST_SQ_C;
      ST_SQ_C: begin
        // Launch the root and the pitch angle together
        sqrt_start = 1'b1;
        cor_start  = 1'b1;
        state_d    = ST_PITCH;
      end
      ST_PITCH: begin
        if (!cor_busy) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cor_y = -{{2{ax_q[15]}}, ax_q};
        cor_x = {2'b00, sqrt_root};
        if (!sqrt_busy) begin
          cor_start = 1'b1;
          state_d   = ST_ROLL;
        end
      end
      ST_ROLL: begin
        if (!cor_busy) begin
          state_d = ST_EMA_MUL;
        end
      end
      ST_EMA_MUL: state_d = ST_EMA_ACC;
      ST_EMA_ACC: state_d = ema_k_q ? ST_YAW_MUL : ST_EMA_MUL;
      ST_YAW_MUL: state_d = ST_YAW_ACC;
      ST_YAW_ACC: state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Multiplier operand selection
  always_comb begin
    case (state_q)
      ST_SQ_A: begin
        mul_a = {{2{ay_q[15]}}, ay_q};
        mul_b = {{18{ay_q[15]}}, ay_q};
      end
      ST_SQ_B: begin
        mul_a = {{2{az_q[15]}}, az_q};
        mul_b = {{18{az_q[15]}}, az_q};
      end
      ST_EMA_MUL: begin
        mul_a = {1'b0, alpha_sat};
        mul_b = ema_diff;
      end
      default: begin
        mul_a = {2'b00, yaw_gain_q};
        mul_b = {{18{dr_q[15]}}, dr_q};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Control and state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cal_done_q  <= 1'b0;
      div_idx_q   <= '0;
      ema_k_q     <= 1'b0;
      yaw_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        sum_q[i] <= '0;
        off_q[i] <= '0;
      end
      for (int k = 0; k < 2; k++) begin
        filt_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;

      // Calibration sample: accumulate unless calibration is complete
      if (accept && !action_i && !cal_done_q) begin
        sum_q[0]  <= sum_q[0] + SUM_W'(accel_x_i);
        sum_q[1]  <= sum_q[1] + SUM_W'(accel_y_i);
        sum_q[2]  <= sum_q[2] + SUM_W'(accel_z_i);
        sum_q[3]  <= sum_q[3] + SUM_W'(rate_z_i);
        count_q   <= last_cal ? '0 : count_q + 1'b1;
        div_idx_q <= '0;
      end

      // Store each mean as it comes out of the divider, less gravity for Z
      if (state_q == ST_DIV_WAIT && !div_busy) begin
        if (div_idx_q == 2'd2) begin
          off_q[div_idx_q] <= 16'(div_quot - {1'b0, gravity_q});
        end else begin
          off_q[div_idx_q] <= div_quot;
        end
        div_idx_q <= div_idx_q + 1'b1;
        if (div_idx_q == 2'd3) begin
          cal_done_q <= 1'b1;
          for (int i = 0; i < 4; i++) begin
            sum_q[i] <= '0;
          end
        end
      end

      if (state_q == ST_ROLL) begin
        ema_k_q <= 1'b0;
      end
      if (state_q == ST_EMA_ACC) begin
        filt_q[ema_k_q] <= ema_f + prod_q[47:16];
        ema_k_q         <= 1'b1;
      end

      // Saturate yaw at the 48-bit limits
      if (state_q == ST_YAW_ACC) begin
        if (yaw_sum[48] != yaw_sum[47]) begin
          yaw_q <= yaw_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end else begin
          yaw_q <= yaw_sum[47:0];
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept && action_i) begin
      ax_q <= 16'(accel_x_i - off_q[0]);
      ay_q <= 16'(accel_y_i - off_q[1]);
      az_q <= 16'(accel_z_i - off_q[2]);
      dr_q <= 16'(rate_z_i - off_q[3]);
    end
    // Hold the Y square while the multiplier forms the Z square
    if (state_q == ST_SQ_B) begin
      ysq_q <= prod_q[31:0];
    end
    if (state_q == ST_PITCH && !cor_busy) begin
      pitch_ang_q <= cor_angle;
    end
    if (state_q == ST_ROLL && !cor_busy) begin
      roll_ang_q <= cor_angle;
    end
    if (out_load) begin
      roll_out_q  <= round_angle(filt_q[0]);
      pitch_out_q <= round_angle(filt_q[1]);
      yaw_out_q   <= yaw_q[47:16];
      cal_out_q   <= cal_done_q;
    end
  end

  ate_divu u_divu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_q[div_idx_q]),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  ate_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (sq_sum),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  ate_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .y_i     (cor_y),
    .x_i     (cor_x),
    .busy_o  (cor_busy),
    .angle_o (cor_angle)
  );

  assign out_valid_o  = out_valid_q;
  assign roll_o       = roll_out_q;
  assign pitch_o      = pitch_out_q;
  assign yaw_o        = yaw_out_q;
  assign calibrated_o = cal_out_q;

`ifndef SYNTHESIS
  // An accepted measurement holds off the next transaction
  a_meas_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i) |=> in_stall_o)
    else $error("measurement accepted without stalling input");

  // A result only appears from the output state
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result raised outside output state");

  // A queued result blocks the sequencer until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_o && out_stall_i) |=> (state_q == ST_OUT))
    else $error("sequencer left output state while result pending");

  // Calibration never undoes itself
  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(cal_done_q))
    else $error("calibration flag cleared");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_q} < 9'(CAL_SAMPLES)))
    else $error("calibration sample count out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ate_divu.sv =====
`default_nettype none

// Divide a signed sum by CAL_SAMPLES with a reciprocal multiply, truncating
// toward zero; the quotient is wrapped to 16 bits. Busy for one cycle.
module ate_divu import ate_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [SUM_W-1:0] sum_i,
  output logic                         busy_o,
  output logic [15:0]                  quot_o
);

  localparam logic [31:0] RECIP = 32'(DIV_MULT);

  logic              busy_q;
  logic              neg_q;
  logic [SUM_W-1:0]  mag_q;
  logic [SUM_W+31:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= sum_i[SUM_W-1];
      mag_q <= sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
    end else if (busy_q) begin
      prod_q <= mag_q * RECIP;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? 16'(-prod_q[DIV_SHIFT +: 16]) : prod_q[DIV_SHIFT +: 16];

endmodule

`default_nettype wire

// ===== hw/rtl/ate_isqrt.sv =====
`default_nettype none

// Floor integer square root of a 32-bit value, two radicand bits a cycle.
module ate_isqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] value_i,
  output logic             busy_o,
  output logic [15:0]      root_o
);

  logic [31:0] rbit_q;
  logic [31:0] v_q;
  logic [31:0] r_q;
  logic [31:0] trial;

  assign trial = r_q + rbit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbit_q <= '0;
    end else if (start_i) begin
      rbit_q <= 32'h4000_0000;
    end else begin
      rbit_q <= rbit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= value_i;
      r_q <= '0;
    end else if (rbit_q != '0) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + rbit_q;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

  assign busy_o = (rbit_q != '0);
  assign root_o = r_q[15:0];

endmodule

`default_nettype wire

// ===== hw/rtl/ate_cordic.sv =====
`default_nettype none

// Vectoring CORDIC: atan2(y, x) in 1/32768 degree, one rotation a cycle,
// clamped to +-180 degrees. A zero vector gives zero.
module ate_cordic import ate_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [17:0]   y_i,
  input  wire logic signed [17:0]   x_i,
  output logic                      busy_o,
  output logic signed [ZW-1:0]      angle_o
);

  localparam logic signed [ZW-1:0] ANG_MAX = ZW'(ANG_LIMIT);
  localparam logic signed [ZW-1:0] ANG_MIN = ZW'(-ANG_LIMIT);

  logic                 busy_q;
  logic [STEP_W-1:0]    cnt_q;
  logic                 zero_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic signed [CW-1:0] x_sc, y_sc, xs, ys;
  logic signed [ZW-1:0] tab;

  assign x_sc = {{(CW-30){x_i[17]}}, x_i, 12'b0};
  assign y_sc = {{(CW-30){y_i[17]}}, y_i, 12'b0};
  assign xs   = x_q >>> cnt_q;
  assign ys   = y_q >>> cnt_q;
  assign tab  = atan_entry(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      // Rotate the left half plane by a quarter turn first
      if (x_i[17] && !y_i[17]) begin
        x_q <= y_sc;
        y_q <= -x_sc;
        z_q <= ZW'(QUARTER);
      end else if (x_i[17]) begin
        x_q <= -y_sc;
        y_q <= x_sc;
        z_q <= ZW'(-QUARTER);
      end else begin
        x_q <= x_sc;
        y_q <= y_sc;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (!y_q[CW-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + tab;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - tab;
      end
    end
  end

  always_comb begin
    if (zero_q) begin
      angle_o = '0;
    end else if (z_q > ANG_MAX) begin
      angle_o = ANG_MAX;
    end else if (z_q < ANG_MIN) begin
      angle_o = ANG_MIN;
    end else begin
      angle_o = z_q;
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire
